// ===== sv/stt_pkg.sv =====
// Shared types, constants and character helpers for the source text tokenizer.
package stt_pkg;

   // Offset and length widths of the result fields
   localparam int OFFSET_BITS = 32;
   localparam int LENGTH_BITS = 16;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

   // Entries in the queue between scanner and emitter
   localparam int QUEUE_DEPTH = 4;

   // Keyword table
   localparam int KW_COUNT    = 6;
   localparam int KW_MAX_LEN  = 8;
   localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);
   localparam int KW_LEN_BITS = $clog2(KW_MAX_LEN + 1);

   // if, else, while, break, continue, return (zero padded)
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
      '{8'h62, 8'h72, 8'h65, 8'h61, 8'h6B, 8'h00, 8'h00, 8'h00},
      '{8'h63, 8'h6F, 8'h6E, 8'h74, 8'h69, 8'h6E, 8'h75, 8'h65},
      '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00}
   };
   localparam logic [KW_LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
      KW_LEN_BITS'(2), KW_LEN_BITS'(4), KW_LEN_BITS'(5),
      KW_LEN_BITS'(5), KW_LEN_BITS'(8), KW_LEN_BITS'(6)
   };

   // Punctuator codes: single operators start at 9, the "x=" pairs at 15
   localparam logic [4:0] OP_CODE_BASE   = 5'd9;
   localparam logic [4:0] PAIR_CODE_BASE = 5'd15;

   // Error codes
   localparam logic [4:0] ERR_BAD_CHAR    = 5'd0;
   localparam logic [4:0] ERR_OPEN_STRING = 5'd1;

   localparam logic [7:0] CHAR_EQUALS = 8'h3D;

   typedef enum logic [2:0] {
      KIND_END     = 3'd0,
      KIND_IDENT   = 3'd1,
      KIND_NUMBER  = 3'd2,
      KIND_STRING  = 3'd3,
      KIND_KEYWORD = 3'd4,
      KIND_PUNCT   = 3'd5,
      KIND_ERROR   = 3'd6
   } token_kind_type;

   typedef enum logic [2:0] {
      CLASS_BLANK,
      CLASS_DIGIT,
      CLASS_ALPHA,
      CLASS_QUOTE,
      CLASS_OPER,
      CLASS_PUNCT,
      CLASS_OTHER
   } char_class_type;

   typedef struct packed {
      token_kind_type         kind;
      logic [4:0]             code;
      logic [OFFSET_BITS-1:0] start;
      logic [LENGTH_BITS-1:0] length;
      logic [7:0]             bad;
      logic                   last;
   } token_type;

   // One queue entry: every token that a single request causes
   typedef struct packed {
      token_type first;
      token_type second;
      logic      two;
   } entry_type;

   // Sort a byte into the scanner's classes
   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      cls = CLASS_OTHER;
      if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A)
         cls = CLASS_BLANK;
      else if (c >= 8'h30 && c <= 8'h39)
         cls = CLASS_DIGIT;
      else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F)
         cls = CLASS_ALPHA;
      else if (c == 8'h22)
         cls = CLASS_QUOTE;
      else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h3D)
         cls = CLASS_OPER;
      else if (c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h7B ||
               c == 8'h7D || c == 8'h2C || c == 8'h3A || c == 8'h3B || c == 8'h26)
         cls = CLASS_PUNCT;
      return cls;
   endfunction

   // Code of a single-character punctuator
   function automatic logic [4:0] punct_code(input logic [7:0] c);
      logic [4:0] code;
      unique case (c)
         8'h28:   code = 5'd0;   // (
         8'h29:   code = 5'd1;   // )
         8'h5B:   code = 5'd2;   // [
         8'h5D:   code = 5'd3;   // ]
         8'h7B:   code = 5'd4;   // {
         8'h7D:   code = 5'd5;   // }
         8'h2C:   code = 5'd6;   // ,
         8'h3A:   code = 5'd7;   // :
         8'h3B:   code = 5'd8;   // ;
         8'h26:   code = 5'd14;  // &
         default: code = 5'd0;
      endcase
      return code;
   endfunction

   // Index of an operator that may take a trailing '='
   function automatic logic [2:0] op_index(input logic [7:0] c);
      logic [2:0] idx;
      unique case (c)
         8'h2B:   idx = 3'd0;    // +
         8'h2D:   idx = 3'd1;    // -
         8'h2A:   idx = 3'd2;    // *
         8'h2F:   idx = 3'd3;    // /
         8'h3D:   idx = 3'd4;    // =
         default: idx = 3'd0;
      endcase
      return idx;
   endfunction

   // Drop keyword candidates that do not have byte c at position idx
   function automatic logic [KW_COUNT-1:0] narrow(input logic [KW_COUNT-1:0] mask,
                                                  input logic in_range,
                                                  input logic [KW_IDX_BITS-1:0] idx,
                                                  input logic [7:0] c);
      logic [KW_COUNT-1:0] keep;
      for (int k = 0; k < KW_COUNT; k++) begin
         keep[k] = mask[k] && in_range && ({1'b0, idx} < KW_LEN[k]) &&
                   (KW_TEXT[k][idx] == c);
      end
      return keep;
   endfunction

endpackage

// ===== sv/stt_if.sv =====
// Request and result channel interfaces of the source text tokenizer.
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, output char_byte, output end_of_text, input ready);
   modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface stt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     token_kind;
   logic [4:0]                     token_code;
   logic [stt_pkg::OFFSET_BITS-1:0] start_offset;
   logic [stt_pkg::LENGTH_BITS-1:0] token_length;
   logic [7:0]                     offending_byte;
   logic                           last_of_run;

   modport source (output valid, output token_kind, output token_code, output start_offset,
                   output token_length, output offending_byte, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_code, input start_offset,
                   input token_length, input offending_byte, input last_of_run,
                   output ready);
endinterface

// ===== sv/stt_scanner.sv =====
// Front part: takes text bytes, classifies them and forms token entries.
module stt_scanner (
   input  logic              clock,
   input  logic              reset,
   stt_req_if.sink           req_bus,
   input  logic              queue_full,
   output logic              push,
   output stt_pkg::entry_type push_entry
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_STRING,
      MODE_OPERATOR,
      MODE_HALTED
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic [stt_pkg::OFFSET_BITS-1:0]   position_ff, position_in;
   logic [stt_pkg::OFFSET_BITS-1:0]   start_ff, start_in;
   logic [stt_pkg::LENGTH_BITS-1:0]   length_ff, length_in;
   logic [stt_pkg::KW_COUNT-1:0]      cands_ff, cands_in;
   logic [2:0]                        op_ff, op_in;

   logic                              accept;
   stt_pkg::char_class_type           cls;
   logic [7:0]                        c;
   logic [stt_pkg::LENGTH_BITS-1:0]   grown;
   logic                              kw_hit;
   logic [4:0]                        kw_code;
   logic                              flush_able;
   stt_pkg::token_type                flush_tok;
   logic                              first_v, second_v;
   stt_pkg::token_type                first_tok, second_tok;
   logic                              do_begin;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign c             = req_bus.char_byte;
   assign cls           = stt_pkg::classify(c);
   assign grown         = (length_ff == stt_pkg::LENGTH_MAX) ? length_ff :
                          length_ff + stt_pkg::LENGTH_BITS'(1);

   // Keyword match: first surviving candidate of exactly the right length
   always_comb begin
      kw_hit  = 1'b0;
      kw_code = 5'd0;
      for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
         if (cands_ff[k] && length_ff == stt_pkg::LENGTH_BITS'(stt_pkg::KW_LEN[k])) begin
            kw_hit  = 1'b1;
            kw_code = 5'(k);
         end
      end
   end

   // Token that the pending number, identifier or operator closes into
   always_comb begin
      flush_tok        = '0;
      flush_tok.start  = start_ff;
      flush_tok.length = length_ff;
      flush_able       = 1'b1;
      case (mode_ff)
         MODE_NUMBER: flush_tok.kind = stt_pkg::KIND_NUMBER;
         MODE_IDENT: begin
            flush_tok.kind = kw_hit ? stt_pkg::KIND_KEYWORD : stt_pkg::KIND_IDENT;
            flush_tok.code = kw_code;
         end
         MODE_OPERATOR: begin
            flush_tok.kind   = stt_pkg::KIND_PUNCT;
            flush_tok.code   = stt_pkg::OP_CODE_BASE + 5'(op_ff);
            flush_tok.length = stt_pkg::LENGTH_BITS'(1);
         end
         default: flush_able = 1'b0;
      endcase
   end

   // Scanner step for one accepted request
   always_comb begin
      mode_in     = mode_ff;
      position_in = position_ff;
      start_in    = start_ff;
      length_in   = length_ff;
      cands_in    = cands_ff;
      op_in       = op_ff;
      first_v     = 1'b0;
      second_v    = 1'b0;
      first_tok   = '0;
      second_tok  = '0;
      do_begin    = 1'b0;

      if (accept && mode_ff != MODE_HALTED) begin
         if (req_bus.end_of_text) begin
            if (mode_ff == MODE_STRING) begin
               first_v          = 1'b1;
               first_tok.kind   = stt_pkg::KIND_ERROR;
               first_tok.code   = stt_pkg::ERR_OPEN_STRING;
               first_tok.start  = start_ff;
               first_tok.length = length_ff;
               mode_in          = MODE_HALTED;
            end else begin
               first_v          = flush_able;
               first_tok        = flush_tok;
               second_v         = 1'b1;
               second_tok.kind  = stt_pkg::KIND_END;
               second_tok.start = position_ff;
               // back to the reset state for a new text
               mode_in          = MODE_IDLE;
               position_in      = '0;
               start_in         = '0;
               length_in        = '0;
               cands_in         = '1;
               op_in            = '0;
            end
         end else begin
            position_in = position_ff + stt_pkg::OFFSET_BITS'(1);
            unique case (mode_ff)
               MODE_NUMBER: begin
                  if (cls == stt_pkg::CLASS_DIGIT)
                     length_in = grown;
                  else
                     do_begin = 1'b1;
               end
               MODE_IDENT: begin
                  if (cls == stt_pkg::CLASS_DIGIT || cls == stt_pkg::CLASS_ALPHA) begin
                     cands_in  = stt_pkg::narrow(cands_ff,
                        length_ff < stt_pkg::LENGTH_BITS'(stt_pkg::KW_MAX_LEN),
                        length_ff[stt_pkg::KW_IDX_BITS-1:0], c);
                     length_in = grown;
                  end else begin
                     do_begin = 1'b1;
                  end
               end
               MODE_STRING: begin
                  length_in = grown;
                  if (cls == stt_pkg::CLASS_QUOTE) begin
                     first_v          = 1'b1;
                     first_tok.kind   = stt_pkg::KIND_STRING;
                     first_tok.start  = start_ff;
                     first_tok.length = grown;
                     mode_in          = MODE_IDLE;
                  end
               end
               MODE_OPERATOR: begin
                  if (c == stt_pkg::CHAR_EQUALS) begin
                     first_v          = 1'b1;
                     first_tok.kind   = stt_pkg::KIND_PUNCT;
                     first_tok.code   = stt_pkg::PAIR_CODE_BASE + 5'(op_ff);
                     first_tok.start  = start_ff;
                     first_tok.length = stt_pkg::LENGTH_BITS'(2);
                     mode_in          = MODE_IDLE;
                     op_in            = '0;
                  end else begin
                     do_begin = 1'b1;
                  end
               end
               MODE_IDLE:   do_begin = 1'b1;
               MODE_HALTED: do_begin = 1'b0;
               default:     do_begin = 1'b0;
            endcase

            // close the pending token, then treat the byte as in idle
            if (do_begin) begin
               first_v   = flush_able;
               first_tok = flush_tok;
               mode_in   = MODE_IDLE;
               op_in     = '0;
               if (cls != stt_pkg::CLASS_BLANK) begin
                  start_in  = position_ff;
                  length_in = stt_pkg::LENGTH_BITS'(1);
               end
               second_tok.start  = position_ff;
               second_tok.length = stt_pkg::LENGTH_BITS'(1);
               unique case (cls)
                  stt_pkg::CLASS_BLANK: mode_in = MODE_IDLE;
                  stt_pkg::CLASS_DIGIT: mode_in = MODE_NUMBER;
                  stt_pkg::CLASS_ALPHA: begin
                     mode_in  = MODE_IDENT;
                     cands_in = stt_pkg::narrow('1, 1'b1, '0, c);
                  end
                  stt_pkg::CLASS_QUOTE: mode_in = MODE_STRING;
                  stt_pkg::CLASS_OPER: begin
                     mode_in = MODE_OPERATOR;
                     op_in   = stt_pkg::op_index(c);
                  end
                  stt_pkg::CLASS_PUNCT: begin
                     second_v        = 1'b1;
                     second_tok.kind = stt_pkg::KIND_PUNCT;
                     second_tok.code = stt_pkg::punct_code(c);
                  end
                  default: begin
                     second_v        = 1'b1;
                     second_tok.kind = stt_pkg::KIND_ERROR;
                     second_tok.code = stt_pkg::ERR_BAD_CHAR;
                     second_tok.bad  = c;
                     mode_in         = MODE_HALTED;
                  end
               endcase
            end
         end
      end
   end

   // Pack the tokens of this request into one queue entry
   always_comb begin
      push             = first_v || second_v;
      push_entry.two   = first_v && second_v;
      push_entry.first = first_v ? first_tok : second_tok;
      push_entry.second = second_tok;
      push_entry.first.last  = !(first_v && second_v);
      push_entry.second.last = 1'b1;
   end

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         position_ff <= '0;
         start_ff    <= '0;
         length_ff   <= '0;
         cands_ff    <= '1;
         op_ff       <= '0;
      end else begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         start_ff    <= start_in;
         length_ff   <= length_in;
         cands_ff    <= cands_in;
         op_ff       <= op_in;
      end
   end

endmodule

// ===== sv/stt_queue.sv =====
// Short queue of token entries between the scanner and the emitter.
module stt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stt_pkg::entry_type push_entry,
   input  logic               pop,
   output stt_pkg::entry_type pop_entry,
   output logic               full,
   output logic               empty
);

   localparam int PTR_BITS   = $clog2(stt_pkg::QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(stt_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(stt_pkg::QUEUE_DEPTH - 1);

   stt_pkg::entry_type      slots_ff [stt_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   assign full      = (count_ff == COUNT_BITS'(stt_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      if (push && !pop)
         count_in = count_ff + COUNT_BITS'(1);
      else if (pop && !push)
         count_in = count_ff - COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push)
         slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== sv/stt_emitter.sv =====
// Back part: hands the tokens of each queue entry out one per cycle while the receiver is ready.
module stt_emitter (
   input  logic               clock,
   input  logic               reset,
   input  stt_pkg::entry_type pop_entry,
   input  logic               empty,
   output logic               pop,
   stt_rsp_if.source          rsp_bus
);

   stt_pkg::token_type out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   stt_pkg::token_type spare_ff, spare_in;
   logic               spare_valid_ff, spare_valid_in;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign pop      = out_free && !spare_valid_ff && !empty;

   // Load the output register: held second token first, then the queue head
   always_comb begin
      out_in         = out_ff;
      out_valid_in   = out_valid_ff;
      spare_in       = spare_ff;
      spare_valid_in = spare_valid_ff;
      if (out_free) begin
         if (spare_valid_ff) begin
            out_in         = spare_ff;
            out_valid_in   = 1'b1;
            spare_valid_in = 1'b0;
         end else if (!empty) begin
            out_in         = pop_entry.first;
            out_valid_in   = 1'b1;
            spare_in       = pop_entry.second;
            spare_valid_in = pop_entry.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spare_ff <= spare_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.token_kind     = out_ff.kind;
   assign rsp_bus.token_code     = out_ff.code;
   assign rsp_bus.start_offset   = out_ff.start;
   assign rsp_bus.token_length   = out_ff.length;
   assign rsp_bus.offending_byte = out_ff.bad;
   assign rsp_bus.last_of_run    = out_ff.last;

endmodule

// ===== sv/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: scanner, entry queue and emitter.
//
// Takes one text byte per request and can accept a request every cycle while
// the queue is not full. The scanner settles each byte in the cycle it is
// accepted and writes the one or two tokens it causes into a four-entry
// queue; the emitter hands tokens out at one per cycle, while the receiver
// is ready, from a registered output that the queue feeds. Bytes that cause
// no token (blanks, letters inside a word) write nothing to the queue; the
// emitter's one token per cycle sets the long-run rate when most bytes close
// two tokens. Identifiers and numbers are reported when the byte after them
// arrives, and one of + - * / = waits a byte for a following '='. A bad byte
// or an open string at end of text gives an error token, after which
// requests are still taken but give nothing until reset.
module source_text_tokenizer (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_bus,
   stt_rsp_if.source rsp_bus
);

   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_empty;
   stt_pkg::entry_type push_entry;
   stt_pkg::entry_type pop_entry;

   stt_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   stt_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

   // The queue is never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("token entry written into a full queue");

   // The queue is never read while empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_empty)
      else $error("token entry read from an empty queue");

   // The second token of a request follows its first without a gap
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_of_run) |=> rsp_bus.valid)
      else $error("second token of a request did not follow the first");

   // End and error tokens always close their request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.token_kind == stt_pkg::KIND_END ||
                         rsp_bus.token_kind == stt_pkg::KIND_ERROR))
      |-> rsp_bus.last_of_run)
      else $error("end or error token not marked last of its request");

endmodule
